/* design/scmcl_pkg.sv */
// ----------------------------------------------------------------------------
// scmcl_pkg
// Shared types, codes and helpers of the sparse cost matrix lookup unit.
// ----------------------------------------------------------------------------
package scmcl_pkg;

   localparam int IMG_AW   = 18;
   localparam int ID_W     = 12;
   localparam int CACHE_AW = 10;

   localparam logic [12:0] MAX_IDS      = 13'd4096;
   localparam logic [20:0] IMG_BYTE_LIM = 21'd1048576;

   typedef enum logic [1:0] {
      FUNC_WRITE  = 2'd0,
      FUNC_BUILD  = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_OVERRUN  = 2'd1,
      STAT_MISALIGN = 2'd2,
      STAT_RANGE    = 2'd3
   } status_type;

   localparam logic [7:0] CSR_RESOLUTION   = 8'd0;
   localparam logic [7:0] CSR_ID_COUNT     = 8'd1;
   localparam logic [7:0] CSR_IMAGE_BYTES  = 8'd2;
   localparam logic [7:0] CSR_INVALID_COST = 8'd3;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_B_START, S_B_ROW, S_B_CS0, S_B_CS1, S_B_VS_CHK, S_B_VS0, S_B_VS1,
      S_B_CHUNK, S_B_COMP, S_B_VALS,
      S_L_START, S_L_TAG, S_L_RANK, S_L_DEF, S_L_VAL, S_L_MUL, S_L_WB
   } fsm_state_type;

   typedef struct packed {
      logic            valid;
      logic [ID_W-1:0] row;
      logic [ID_W-1:0] col;
      logic [31:0]     cost;
   } cache_line_type;

   typedef struct packed {
      logic [IMG_AW-1:0] chunk_wa;
      logic [IMG_AW-1:0] compact_wa;
      logic [15:0]       compact_size;
      logic [19:0]       values_off;
   } row_base_type;

   typedef struct packed {
      logic [31:0] word;
      logic [4:0]  bit_sel;
      logic        last;
   } rank_req_type;

   typedef struct packed {
      logic [5:0] ones;
      logic       hit_bit;
   } rank_rsp_type;

   function automatic logic [7:0] byte_sel(input logic [31:0] word, input logic [1:0] sel);
      logic [31:0] sh;
      sh = word >> {sel, 3'b000};
      return sh[7:0];
   endfunction

endpackage

/* design/scmcl_rank_unit.sv */
// ----------------------------------------------------------------------------
// scmcl_rank_unit
// Masked popcount of one bitmap word, shared by both rank levels.
// ----------------------------------------------------------------------------
module scmcl_rank_unit (
   input  scmcl_pkg::rank_req_type rank_req,
   output scmcl_pkg::rank_rsp_type rank_rsp
);

   logic [31:0] mask;
   logic [31:0] masked;
   logic [1:0]  s1 [16];
   logic [2:0]  s2 [8];
   logic [3:0]  s3 [4];
   logic [4:0]  s4 [2];

   // only the word holding the position is cut below it
   assign mask   = rank_req.last ? ((32'd1 << rank_req.bit_sel) - 32'd1) : '1;
   assign masked = rank_req.word & mask;

   always_comb begin
      for (int k = 0; k < 16; k++) begin
         s1[k] = {1'b0, masked[2*k]} + {1'b0, masked[2*k+1]};
      end
      for (int k = 0; k < 8; k++) begin
         s2[k] = {1'b0, s1[2*k]} + {1'b0, s1[2*k+1]};
      end
      for (int k = 0; k < 4; k++) begin
         s3[k] = {1'b0, s2[2*k]} + {1'b0, s2[2*k+1]};
      end
      for (int k = 0; k < 2; k++) begin
         s4[k] = {1'b0, s3[2*k]} + {1'b0, s3[2*k+1]};
      end
   end

   assign rank_rsp.ones    = {1'b0, s4[0]} + {1'b0, s4[1]};
   assign rank_rsp.hit_bit = rank_req.word[rank_req.bit_sel];

endmodule

/* design/sparse_cost_matrix_cached_lookup_unit.sv */
// ----------------------------------------------------------------------------
// sparse_cost_matrix_cached_lookup_unit
// Sparse cost matrix image store, row index build and cached rank lookup.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A cache hit answers from the tag
// check; a miss ranks the chunk bitmap and, where its bit is set, the compact
// bitmap, one word at a time through one shared popcount unit fed by the
// single image read port, then reads the row default (absent entry) or the
// stored value. A successful row index build ends with a cache clearing pass,
// and a cache clear runs the same pass. After reset a clearing pass runs
// before the first transaction is taken; configuration writes are taken at
// any time.
module sparse_cost_matrix_cached_lookup_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // word_address[17:0], data_word[49:18], row_id[61:50], column_id[73:62]
   input  logic [79:0] req_tdata,
   // func[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cost[31:0]
   output logic [31:0] rsp_tdata,
   // cache_hit[0], status[2:1]
   output logic [2:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int AW = scmcl_pkg::IMG_AW;
   localparam int CW = scmcl_pkg::CACHE_AW;

   // memories
   logic [31:0]               image_mem [1 << AW];
   scmcl_pkg::row_base_type   rb_mem    [1 << scmcl_pkg::ID_W];
   scmcl_pkg::cache_line_type cache_mem [1 << CW];

   logic [31:0]               img_rdata_ff;
   scmcl_pkg::row_base_type   rb_rdata_ff;
   scmcl_pkg::cache_line_type cache_rdata_ff;

   logic [AW-1:0]             img_raddr;
   logic                      cache_we;
   logic [CW-1:0]             cache_waddr;
   scmcl_pkg::cache_line_type cache_wdata;
   logic [CW-1:0]             cache_raddr;
   logic                      rb_we;
   scmcl_pkg::row_base_type   rb_wdata;

   // control
   scmcl_pkg::fsm_state_type state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_cost_ff, rsp_cost_in;
   logic        rsp_hit_ff, rsp_hit_in;
   scmcl_pkg::status_type rsp_status_ff, rsp_status_in;

   logic [15:0] res_ff;
   logic [12:0] idc_ff;
   logic [20:0] ibytes_ff;
   logic [15:0] inval_ff;

   logic        built_ff, built_in;
   logic [12:0] built_ids_ff, built_ids_in;
   logic [9:0]  clr_cnt_ff, clr_cnt_in;
   logic        clr_rsp_ff, clr_rsp_in;

   logic [11:0] row_ff, row_in;
   logic [11:0] col_ff, col_in;

   logic [12:0] n_ff, n_in;
   logic [20:0] end_ff, end_in;
   logic [6:0]  chunk_ff, chunk_in;
   logic [20:0] ptr_ff, ptr_in;
   logic [12:0] idx_ff, idx_in;
   logic [15:0] cs_ff, cs_in;
   logic [15:0] vs_ff, vs_in;
   logic [7:0]  lo_ff, lo_in;
   logic [AW-1:0] chunk_wa_ff, chunk_wa_in;
   logic [AW-1:0] comp_wa_ff, comp_wa_in;

   logic [AW-1:0] rk_base_ff, rk_base_in;
   logic [11:0] rk_pos_ff, rk_pos_in;
   logic [6:0]  rk_j_ff, rk_j_in;
   logic [11:0] rk_cnt_ff, rk_cnt_in;
   logic        rk_comp_ff, rk_comp_in;
   logic [1:0]  vsel_ff, vsel_in;
   logic [15:0] val_ff, val_in;
   logic [31:0] cost_ff, cost_in;

   scmcl_pkg::rank_req_type rank_req;
   scmcl_pkg::rank_rsp_type rank_rsp;

   logic        req_accept;
   logic        rsp_accept;
   logic [20:0] rem;
   logic [12:0] n_clamp;
   logic [20:0] end_clamp;
   logic [9:0]  nbytes;
   logic [13:0] ptr0;
   logic [13:0] row3;
   logic        rk_last;
   logic [11:0] rk_cnt_new;
   logic [11:0] comp_pos;
   logic [19:0] vaddr;
   logic [7:0]  vbyte;
   logic [20:0] ptr_p1;

   assign req_accept = req_tvalid & req_tready;
   assign rsp_accept = rsp_tvalid & rsp_tready;
   assign req_tready = (state_ff == scmcl_pkg::S_IDLE) & ~rsp_valid_ff;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_cost_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_hit_ff};

   assign rem       = end_ff - ptr_ff;
   assign n_clamp   = (idc_ff > scmcl_pkg::MAX_IDS) ? scmcl_pkg::MAX_IDS : idc_ff;
   assign end_clamp = (ibytes_ff > scmcl_pkg::IMG_BYTE_LIM) ? scmcl_pkg::IMG_BYTE_LIM
                                                             : ibytes_ff;
   assign nbytes    = 10'((n_clamp + 13'd7) >> 3);
   assign ptr0      = {(n_clamp + {12'd0, n_clamp[0]}), 1'b0};
   assign row3      = {2'b00, row_ff} + {1'b0, row_ff, 1'b0} + {2'b00, col_ff};
   assign cache_raddr = row3[CW-1:0];
   assign ptr_p1    = ptr_ff + 21'd1;

   assign rk_last    = (rk_j_ff == rk_pos_ff[11:5]);
   assign rank_req   = '{word: img_rdata_ff, bit_sel: rk_pos_ff[4:0], last: rk_last};
   assign rk_cnt_new = rk_cnt_ff + {6'd0, rank_rsp.ones};
   assign comp_pos   = {rk_cnt_new[8:0], col_ff[2:0]};
   assign vaddr      = (res_ff != 16'd1)
                       ? rb_rdata_ff.values_off + {8'd0, rk_cnt_new}
                       : rb_rdata_ff.values_off + {7'd0, rk_cnt_new, 1'b0};
   assign vbyte      = scmcl_pkg::byte_sel(img_rdata_ff, vsel_ff);

   scmcl_rank_unit u_rank (
      .rank_req (rank_req),
      .rank_rsp (rank_rsp)
   );

   // memories
   always_ff @(posedge clock) begin
      if (req_accept && (scmcl_pkg::func_type'(req_tuser) == scmcl_pkg::FUNC_WRITE)) begin
         image_mem[req_tdata[17:0]] <= req_tdata[49:18];
      end
      img_rdata_ff <= image_mem[img_raddr];
   end

   always_ff @(posedge clock) begin
      if (rb_we) begin
         rb_mem[idx_ff[11:0]] <= rb_wdata;
      end
      rb_rdata_ff <= rb_mem[row_ff];
   end

   always_ff @(posedge clock) begin
      if (cache_we) begin
         cache_mem[cache_waddr] <= cache_wdata;
      end
      cache_rdata_ff <= cache_mem[cache_raddr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff    <= 16'd1;
         idc_ff    <= 13'd4096;
         ibytes_ff <= 21'd0;
         inval_ff  <= 16'd30000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            scmcl_pkg::CSR_RESOLUTION:   res_ff    <= csr_data[15:0];
            scmcl_pkg::CSR_ID_COUNT:     idc_ff    <= csr_data[12:0];
            scmcl_pkg::CSR_IMAGE_BYTES:  ibytes_ff <= csr_data[20:0];
            scmcl_pkg::CSR_INVALID_COST: inval_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scmcl_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
         built_ff     <= 1'b0;
         built_ids_ff <= 13'd0;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         built_ff     <= built_in;
         built_ids_ff <= built_ids_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cost_ff   <= rsp_cost_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      n_ff          <= n_in;
      end_ff        <= end_in;
      chunk_ff      <= chunk_in;
      ptr_ff        <= ptr_in;
      idx_ff        <= idx_in;
      cs_ff         <= cs_in;
      vs_ff         <= vs_in;
      lo_ff         <= lo_in;
      chunk_wa_ff   <= chunk_wa_in;
      comp_wa_ff    <= comp_wa_in;
      rk_base_ff    <= rk_base_in;
      rk_pos_ff     <= rk_pos_in;
      rk_j_ff       <= rk_j_in;
      rk_cnt_ff     <= rk_cnt_in;
      rk_comp_ff    <= rk_comp_in;
      vsel_ff       <= vsel_in;
      val_ff        <= val_in;
      cost_ff       <= cost_in;
   end

   always_comb begin
      logic        finish;
      logic [31:0] fin_cost;
      logic        fin_hit;
      scmcl_pkg::status_type fin_status;

      finish       = 1'b0;
      fin_cost     = 32'd0;
      fin_hit      = 1'b0;
      fin_status   = scmcl_pkg::STAT_OK;

      state_in     = state_ff;
      built_in     = built_ff;
      built_ids_in = built_ids_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_rsp_in   = clr_rsp_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      n_in         = n_ff;
      end_in       = end_ff;
      chunk_in     = chunk_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      cs_in        = cs_ff;
      vs_in        = vs_ff;
      lo_in        = lo_ff;
      chunk_wa_in  = chunk_wa_ff;
      comp_wa_in   = comp_wa_ff;
      rk_base_in   = rk_base_ff;
      rk_pos_in    = rk_pos_ff;
      rk_j_in      = rk_j_ff;
      rk_cnt_in    = rk_cnt_ff;
      rk_comp_in   = rk_comp_ff;
      vsel_in      = vsel_ff;
      val_in       = val_ff;
      cost_in      = cost_ff;

      img_raddr    = ptr_ff[19:2];
      cache_we     = 1'b0;
      cache_waddr  = cache_raddr;
      cache_wdata  = '{valid: 1'b1, row: row_ff, col: col_ff, cost: cost_ff};
      rb_we        = 1'b0;
      rb_wdata     = '{chunk_wa: chunk_wa_ff, compact_wa: comp_wa_ff,
                       compact_size: cs_ff, values_off: ptr_ff[19:0]};

      case (state_ff)
         scmcl_pkg::S_CLEAR: begin
            cache_we    = 1'b1;
            cache_waddr = clr_cnt_ff;
            cache_wdata = '0;
            clr_cnt_in  = clr_cnt_ff + 10'd1;
            if (clr_cnt_ff == '1) begin
               finish     = clr_rsp_ff;
               clr_rsp_in = 1'b0;
               state_in   = scmcl_pkg::S_IDLE;
            end
         end

         scmcl_pkg::S_IDLE: begin
            if (req_accept) begin
               row_in = req_tdata[61:50];
               col_in = req_tdata[73:62];
               case (scmcl_pkg::func_type'(req_tuser))
                  scmcl_pkg::FUNC_WRITE:  finish   = 1'b1;
                  scmcl_pkg::FUNC_BUILD:  state_in = scmcl_pkg::S_B_START;
                  scmcl_pkg::FUNC_LOOKUP: state_in = scmcl_pkg::S_L_START;
                  scmcl_pkg::FUNC_CLEAR: begin
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = scmcl_pkg::S_CLEAR;
                  end
                  default: ;
               endcase
            end
         end

         // row index build
         scmcl_pkg::S_B_START: begin
            built_in = 1'b0;
            n_in     = n_clamp;
            end_in   = end_clamp;
            chunk_in = {5'((nbytes + 10'd31) >> 5), 2'b00};
            ptr_in   = {7'd0, ptr0};
            idx_in   = 13'd0;
            if (end_clamp < {7'd0, ptr0}) begin
               finish     = 1'b1;
               fin_status = scmcl_pkg::STAT_OVERRUN;
               state_in   = scmcl_pkg::S_IDLE;
            end else begin
               state_in = scmcl_pkg::S_B_ROW;
            end
         end

         scmcl_pkg::S_B_ROW: begin
            if (idx_ff == n_ff) begin
               built_in     = 1'b1;
               built_ids_in = n_ff;
               clr_cnt_in   = '0;
               clr_rsp_in   = 1'b1;
               state_in     = scmcl_pkg::S_CLEAR;
            end else if (rem < 21'd2) begin
               finish     = 1'b1;
               fin_status = scmcl_pkg::STAT_OVERRUN;
               state_in   = scmcl_pkg::S_IDLE;
            end else begin
               state_in = scmcl_pkg::S_B_CS0;
            end
         end

         scmcl_pkg::S_B_CS0: begin
            lo_in     = scmcl_pkg::byte_sel(img_rdata_ff, ptr_ff[1:0]);
            img_raddr = ptr_p1[19:2];
            state_in  = scmcl_pkg::S_B_CS1;
         end

         scmcl_pkg::S_B_CS1: begin
            cs_in    = {scmcl_pkg::byte_sel(img_rdata_ff, ptr_p1[1:0]), lo_ff};
            ptr_in   = ptr_ff + 21'd2;
            state_in = scmcl_pkg::S_B_VS_CHK;
         end

         scmcl_pkg::S_B_VS_CHK: begin
            if (rem < 21'd2) begin
               finish     = 1'b1;
               fin_status = scmcl_pkg::STAT_OVERRUN;
               state_in   = scmcl_pkg::S_IDLE;
            end else begin
               state_in = scmcl_pkg::S_B_VS0;
            end
         end

         scmcl_pkg::S_B_VS0: begin
            lo_in     = scmcl_pkg::byte_sel(img_rdata_ff, ptr_ff[1:0]);
            img_raddr = ptr_p1[19:2];
            state_in  = scmcl_pkg::S_B_VS1;
         end

         scmcl_pkg::S_B_VS1: begin
            vs_in    = {scmcl_pkg::byte_sel(img_rdata_ff, ptr_p1[1:0]), lo_ff};
            ptr_in   = ptr_ff + 21'd2;
            state_in = scmcl_pkg::S_B_CHUNK;
         end

         scmcl_pkg::S_B_CHUNK: begin
            if (rem < {14'd0, chunk_ff}) begin
               finish     = 1'b1;
               fin_status = scmcl_pkg::STAT_OVERRUN;
               state_in   = scmcl_pkg::S_IDLE;
            end else if (ptr_ff[1:0] != 2'b00) begin
               finish     = 1'b1;
               fin_status = scmcl_pkg::STAT_MISALIGN;
               state_in   = scmcl_pkg::S_IDLE;
            end else begin
               chunk_wa_in = ptr_ff[19:2];
               ptr_in      = ptr_ff + {14'd0, chunk_ff};
               state_in    = scmcl_pkg::S_B_COMP;
            end
         end

         scmcl_pkg::S_B_COMP: begin
            if (rem < {5'd0, cs_ff}) begin
               finish     = 1'b1;
               fin_status = scmcl_pkg::STAT_OVERRUN;
               state_in   = scmcl_pkg::S_IDLE;
            end else if (ptr_ff[1:0] != 2'b00) begin
               finish     = 1'b1;
               fin_status = scmcl_pkg::STAT_MISALIGN;
               state_in   = scmcl_pkg::S_IDLE;
            end else begin
               comp_wa_in = ptr_ff[19:2];
               ptr_in     = ptr_ff + {5'd0, cs_ff};
               state_in   = scmcl_pkg::S_B_VALS;
            end
         end

         scmcl_pkg::S_B_VALS: begin
            if (rem < {5'd0, vs_ff}) begin
               finish     = 1'b1;
               fin_status = scmcl_pkg::STAT_OVERRUN;
               state_in   = scmcl_pkg::S_IDLE;
            end else if (ptr_ff[1:0] != 2'b00) begin
               finish     = 1'b1;
               fin_status = scmcl_pkg::STAT_MISALIGN;
               state_in   = scmcl_pkg::S_IDLE;
            end else begin
               rb_we    = 1'b1;
               ptr_in   = ptr_ff + {5'd0, vs_ff};
               idx_in   = idx_ff + 13'd1;
               state_in = scmcl_pkg::S_B_ROW;
            end
         end

         // lookup
         scmcl_pkg::S_L_START: begin
            if (!built_ff) begin
               finish     = 1'b1;
               fin_status = scmcl_pkg::STAT_OVERRUN;
               state_in   = scmcl_pkg::S_IDLE;
            end else if (({1'b0, row_ff} >= built_ids_ff) ||
                         ({1'b0, col_ff} >= built_ids_ff)) begin
               finish     = 1'b1;
               fin_status = scmcl_pkg::STAT_RANGE;
               state_in   = scmcl_pkg::S_IDLE;
            end else begin
               state_in = scmcl_pkg::S_L_TAG;
            end
         end

         scmcl_pkg::S_L_TAG: begin
            if (cache_rdata_ff.valid && (cache_rdata_ff.row == row_ff) &&
                (cache_rdata_ff.col == col_ff)) begin
               finish   = 1'b1;
               fin_cost = cache_rdata_ff.cost;
               fin_hit  = 1'b1;
               state_in = scmcl_pkg::S_IDLE;
            end else begin
               img_raddr  = rb_rdata_ff.chunk_wa;
               rk_base_in = rb_rdata_ff.chunk_wa;
               rk_pos_in  = {3'd0, col_ff[11:3]};
               rk_j_in    = 7'd0;
               rk_cnt_in  = 12'd0;
               rk_comp_in = 1'b0;
               state_in   = scmcl_pkg::S_L_RANK;
            end
         end

         // one bitmap word per cycle through the popcount unit
         scmcl_pkg::S_L_RANK: begin
            rk_cnt_in = rk_cnt_new;
            rk_j_in   = rk_j_ff + 7'd1;
            img_raddr = rk_base_ff + {11'd0, rk_j_ff} + 18'd1;
            if (rk_last) begin
               if (!rank_rsp.hit_bit ||
                   (!rk_comp_ff && ({7'd0, comp_pos} >=
                                    {rb_rdata_ff.compact_size, 3'b000}))) begin
                  // absent entry: row default
                  img_raddr = {7'd0, row_ff[11:1]};
                  state_in  = scmcl_pkg::S_L_DEF;
               end else if (!rk_comp_ff) begin
                  img_raddr  = rb_rdata_ff.compact_wa;
                  rk_base_in = rb_rdata_ff.compact_wa;
                  rk_pos_in  = comp_pos;
                  rk_j_in    = 7'd0;
                  rk_cnt_in  = 12'd0;
                  rk_comp_in = 1'b1;
               end else begin
                  img_raddr = {vaddr[19:2]};
                  vsel_in   = vaddr[1:0];
                  state_in  = scmcl_pkg::S_L_VAL;
               end
            end
         end

         scmcl_pkg::S_L_DEF: begin
            cost_in  = {16'd0, row_ff[0] ? img_rdata_ff[31:16] : img_rdata_ff[15:0]};
            state_in = scmcl_pkg::S_L_WB;
         end

         scmcl_pkg::S_L_VAL: begin
            if (res_ff != 16'd1) begin
               val_in = (vbyte == 8'hFF) ? inval_ff : {8'd0, vbyte};
            end else begin
               val_in = vsel_ff[1] ? img_rdata_ff[31:16] : img_rdata_ff[15:0];
            end
            state_in = scmcl_pkg::S_L_MUL;
         end

         scmcl_pkg::S_L_MUL: begin
            cost_in  = val_ff * res_ff;
            state_in = scmcl_pkg::S_L_WB;
         end

         scmcl_pkg::S_L_WB: begin
            cache_we = 1'b1;
            finish   = 1'b1;
            fin_cost = cost_ff;
            state_in = scmcl_pkg::S_IDLE;
         end

         default: state_in = scmcl_pkg::S_IDLE;
      endcase

      rsp_valid_in  = finish | (rsp_valid_ff & ~rsp_accept);
      rsp_cost_in   = finish ? fin_cost   : rsp_cost_ff;
      rsp_hit_in    = finish ? fin_hit    : rsp_hit_ff;
      rsp_status_in = finish ? fin_status : rsp_status_ff;
   end

   // checks
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_status_ff == scmcl_pkg::STAT_OK)
      else $error("cache hit reported with a fault status");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != scmcl_pkg::STAT_OK) |-> rsp_cost_ff == 32'd0)
      else $error("fault transaction returned a nonzero cost");

   a_busy_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == scmcl_pkg::S_CLEAR |-> !req_tready)
      else $error("request taken during cache clearing pass");

   a_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == scmcl_pkg::S_L_TAG |-> built_ff && ({1'b0, row_ff} < built_ids_ff))
      else $error("lookup proceeded without a valid row index");

endmodule

/* dv/sparse_cost_matrix_cached_lookup_unit_test.sv */
// ----------------------------------------------------------------------------
// sparse_cost_matrix_cached_lookup_unit_test
// Loads small cost matrix images, mostly well-formed, builds the row index under
// several register settings and checks every lookup, build, write and cache
// clear response against a cycle-free prediction of the matrix and its cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_cost_matrix_cached_lookup_unit_test;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int ITEM_TARGET    = 1150;

   typedef struct {
      scmcl_pkg::func_type func;
      bit [17:0]   addr;
      bit [31:0]   data;
      bit [11:0]   row;
      bit [11:0]   col;
   } matrix_op_type;

   typedef struct {
      bit [31:0]  cost;
      bit         hit;
      scmcl_pkg::status_type status;
   } cost_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   sparse_cost_matrix_cached_lookup_unit u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predicted state of the block
   bit [31:0]   img_mem [0:262143];
   int unsigned rb_chunk [0:4095];
   int unsigned rb_comp [0:4095];
   int unsigned rb_csize [0:4095];
   int unsigned rb_vals [0:4095];
   bit          cl_valid [0:1023];
   bit [11:0]   cl_row [0:1023];
   bit [11:0]   cl_col [0:1023];
   bit [31:0]   cl_cost [0:1023];
   bit          index_ok = 0;
   int unsigned index_rows = 0;
   int unsigned cfg_res = 1;
   int unsigned cfg_ids = 4096;
   int unsigned cfg_bytes = 0;
   int unsigned cfg_invalid = 30000;

   matrix_op_type   pending_q[$];
   cost_result_type cost_expect_q[$];
   matrix_op_type   cur_op;
   bit           req_took = 0;
   int           n_sent = 0;
   int           n_queued = 0;
   int           errors = 0;
   int           quiet_cycles = 0;

   function automatic bit [7:0] img_byte(bit [31:0] b);
      bit [31:0] w;
      w = img_mem[b[19:2]] >> {b[1:0], 3'b000};
      return w[7:0];
   endfunction

   function automatic bit [15:0] img_half(bit [31:0] b);
      return {img_byte(b + 1), img_byte(b)};
   endfunction

   function automatic bit img_bit(bit [31:0] base, bit [31:0] pos);
      bit [7:0] v;
      v = img_byte(base + (pos >> 3));
      return v[pos[2:0]];
   endfunction

   function automatic int unsigned ones_below(bit [31:0] base, bit [31:0] pos);
      int unsigned cnt;
      cnt = 0;
      for (int unsigned i = 0; i < pos; i++) cnt += img_bit(base, i);
      return cnt;
   endfunction

   function automatic void flush_cache();
      foreach (cl_valid[i]) cl_valid[i] = 0;
   endfunction

   function automatic scmcl_pkg::status_type build_rows();
      int unsigned n, lim, csz, ptr, cs, vs;
      n = (cfg_ids > 4096) ? 4096 : cfg_ids;
      lim = (cfg_bytes > 1048576) ? 1048576 : cfg_bytes;
      csz = (((n + 7) / 8 + 31) / 32) * 4;
      ptr = (n + (n & 1)) * 2;
      index_ok = 0;
      if (lim < ptr) return scmcl_pkg::STAT_OVERRUN;
      for (int unsigned i = 0; i < n; i++) begin
         if (lim - ptr < 2) return scmcl_pkg::STAT_OVERRUN;
         cs = img_half(ptr);
         ptr += 2;
         if (lim - ptr < 2) return scmcl_pkg::STAT_OVERRUN;
         vs = img_half(ptr);
         ptr += 2;
         if (lim - ptr < csz) return scmcl_pkg::STAT_OVERRUN;
         if (ptr & 3) return scmcl_pkg::STAT_MISALIGN;
         rb_chunk[i] = ptr;
         ptr += csz;
         if (lim - ptr < cs) return scmcl_pkg::STAT_OVERRUN;
         if (ptr & 3) return scmcl_pkg::STAT_MISALIGN;
         rb_comp[i] = ptr;
         rb_csize[i] = cs;
         ptr += cs;
         if (lim - ptr < vs) return scmcl_pkg::STAT_OVERRUN;
         if (ptr & 3) return scmcl_pkg::STAT_MISALIGN;
         rb_vals[i] = ptr;
         ptr += vs;
      end
      index_ok = 1;
      index_rows = n;
      flush_cache();
      return scmcl_pkg::STAT_OK;
   endfunction

   function automatic bit [31:0] matrix_cost(int unsigned r, int unsigned c);
      int unsigned cpos, comp_pos, vpos;
      bit [31:0] v;
      cpos = c >> 3;
      if (!img_bit(rb_chunk[r], cpos)) return img_half(r * 2);
      comp_pos = ones_below(rb_chunk[r], cpos) * 8 + (c & 7);
      if (comp_pos >= rb_csize[r] * 8 || !img_bit(rb_comp[r], comp_pos))
         return img_half(r * 2);
      vpos = ones_below(rb_comp[r], comp_pos);
      if (cfg_res != 1) begin
         v = img_byte(rb_vals[r] + vpos);
         if (v == 255) v = cfg_invalid;
      end else begin
         v = img_half(rb_vals[r] + vpos * 2);
      end
      return v * cfg_res;
   endfunction

   function automatic cost_result_type predict_cost(matrix_op_type op);
      cost_result_type res;
      int unsigned h;
      res = '{cost: 0, hit: 0, status: scmcl_pkg::STAT_OK};
      case (op.func)
         scmcl_pkg::FUNC_WRITE: img_mem[op.addr] = op.data;
         scmcl_pkg::FUNC_BUILD: res.status = build_rows();
         scmcl_pkg::FUNC_CLEAR: flush_cache();
         default: begin
            if (!index_ok) res.status = scmcl_pkg::STAT_OVERRUN;
            else if (op.row >= index_rows || op.col >= index_rows)
               res.status = scmcl_pkg::STAT_RANGE;
            else begin
               h = (3 * op.row + op.col) % 1024;
               if (cl_valid[h] && cl_row[h] == op.row && cl_col[h] == op.col) begin
                  res.cost = cl_cost[h];
                  res.hit = 1;
               end else begin
                  res.cost = matrix_cost(op.row, op.col);
                  cl_valid[h] = 1;
                  cl_row[h] = op.row;
                  cl_col[h] = op.col;
                  cl_cost[h] = res.cost;
               end
            end
         end
      endcase
      return res;
   endfunction

   // sender: a new transaction is offered only once the previous one is taken
   always @(negedge clock) begin
      int idle_pct;
      idle_pct = (n_sent < ITEM_TARGET / 3) ? 29 : (n_sent < 2 * ITEM_TARGET / 3) ? 76 : 0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            cur_op = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {6'b0, cur_op.col, cur_op.row, cur_op.data, cur_op.addr};
            req_tuser <= cur_op.func;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_took = !reset && req_tvalid && req_tready;
      if (req_took) begin
         cost_expect_q.push_back(predict_cost(cur_op));
         n_sent++;
      end
   end

   // receiver, with one long hold-off while the sender keeps going
   always @(negedge clock) begin
      static int hold_left = 0;
      static bit held = 0;
      int idle_pct;
      idle_pct = (n_sent < ITEM_TARGET / 3) ? 76 : (n_sent < 2 * ITEM_TARGET / 3) ? 29 : 0;
      if (!held && n_sent >= 200) begin
         held = 1;
         hold_left = 600;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      cost_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cost_expect_q.size() == 0) begin
            $error("response with no transaction outstanding: cost %0d", rsp_tdata);
            errors++;
         end else begin
            exp_res = cost_expect_q.pop_front();
            if (rsp_tdata !== exp_res.cost) begin
               $error("cost: expected %0d, got %0d", exp_res.cost, rsp_tdata);
               errors++;
            end
            if (rsp_tuser[0] !== exp_res.hit) begin
               $error("cache_hit: expected %0d, got %0d", exp_res.hit, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tuser[2:1] !== exp_res.status) begin
               $error("status: expected %0d, got %0d", exp_res.status, rsp_tuser[2:1]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_op(scmcl_pkg::func_type f, bit [17:0] a, bit [31:0] d, bit [11:0] r,
                         bit [11:0] c);
      pending_q.push_back('{func: f, addr: a, data: d, row: r, col: c});
      n_queued++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_q.size() > 0 || req_tvalid || cost_expect_q.size() > 0)
         @(negedge clock);
   endtask

   task automatic write_csr(bit [7:0] idx, bit [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         scmcl_pkg::CSR_RESOLUTION:  cfg_res = val[15:0];
         scmcl_pkg::CSR_ID_COUNT:    cfg_ids = val[12:0];
         scmcl_pkg::CSR_IMAGE_BYTES: cfg_bytes = val[20:0];
         default:                    cfg_invalid = val[15:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // lays out an image, well-formed unless misalign is set; values blocks hold at
   // least what the compact bits can reach, so no lookup touches an unwritten word
   task automatic make_image(int unsigned n, bit misalign, output bit [7:0] img_q[$]);
      int unsigned cs, pc, vs;
      bit [7:0] b;
      img_q = {};
      repeat ((n + (n & 1)) * 2) img_q.push_back(8'($urandom));
      for (int unsigned i = 0; i < n; i++) begin
         cs = (misalign && i == 0) ? 2 : 4 * $urandom_range(2);
         vs = 0;
         img_q.push_back(cs[7:0]);
         img_q.push_back(cs[15:8]);
         img_q.push_back(8'h00);
         img_q.push_back(8'h00);
         // size of values patched once the compact bits are known
         repeat (4) img_q.push_back(8'($urandom));
         pc = 0;
         for (int unsigned k = 0; k < cs; k++) begin
            b = 8'($urandom);
            pc += $countones(b);
            img_q.push_back(b);
         end
         vs = ((2 * pc + 3) / 4) * 4;
         img_q[img_q.size() - cs - 6] = vs[7:0];
         img_q[img_q.size() - cs - 5] = vs[15:8];
         for (int unsigned k = 0; k < vs; k++)
            img_q.push_back(($urandom_range(7) == 0) ? 8'hFF : 8'($urandom));
      end
   endtask

   task automatic load_image(bit [7:0] img_q[$]);
      while (img_q.size() % 4) img_q.push_back(8'h00);
      for (int unsigned w = 0; w < img_q.size() / 4; w++)
         add_op(scmcl_pkg::FUNC_WRITE, 18'(w),
                {img_q[4*w+3], img_q[4*w+2], img_q[4*w+1], img_q[4*w]}, 0, 0);
   endtask

   initial begin
      bit [7:0] img_q[$];
      int unsigned n, total, pick;
      bit [11:0] r, c;
      int phase;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lookup before any build, clear, build into an empty image, address extremes
      add_op(scmcl_pkg::FUNC_LOOKUP, 0, 0, 0, 0);
      add_op(scmcl_pkg::FUNC_CLEAR, 0, 0, 0, 0);
      add_op(scmcl_pkg::FUNC_BUILD, 0, 0, 0, 0);
      add_op(scmcl_pkg::FUNC_WRITE, 18'h0, 32'h0, 0, 0);
      add_op(scmcl_pkg::FUNC_WRITE, 18'h3FFFF, 32'hFFFFFFFF, 12'hFFF, 12'hFFF);
      add_op(scmcl_pkg::FUNC_LOOKUP, 0, 0, 12'hFFF, 12'hFFF);
      wait_drained();
      // empty matrix builds fine, every id is out of range
      write_csr(scmcl_pkg::CSR_ID_COUNT, 0);
      add_op(scmcl_pkg::FUNC_BUILD, 0, 0, 0, 0);
      add_op(scmcl_pkg::FUNC_LOOKUP, 0, 0, 0, 0);
      add_op(scmcl_pkg::FUNC_LOOKUP, 0, 0, 12'hFFF, 0);
      wait_drained();
      // oversized id count is clamped and overruns the short image
      write_csr(scmcl_pkg::CSR_ID_COUNT, 13'h1FFF);
      add_op(scmcl_pkg::FUNC_BUILD, 0, 0, 0, 0);
      wait_drained();

      phase = 0;
      while (n_queued < ITEM_TARGET) begin
         n = (phase == 0) ? 5 : (phase == 3) ? 1 : $urandom_range(2, 12);
         make_image(n, phase == 1, img_q);
         total = img_q.size();
         case (phase % 5)
            0: write_csr(scmcl_pkg::CSR_RESOLUTION, 1);
            1: write_csr(scmcl_pkg::CSR_RESOLUTION, 7);
            2: write_csr(scmcl_pkg::CSR_RESOLUTION, 16'hFFFF);
            3: write_csr(scmcl_pkg::CSR_RESOLUTION, 0);
            default: write_csr(scmcl_pkg::CSR_RESOLUTION,
                               ($urandom_range(1)) ? 1 : $urandom_range(65535));
         endcase
         case (phase % 3)
            0: write_csr(scmcl_pkg::CSR_INVALID_COST, 0);
            1: write_csr(scmcl_pkg::CSR_INVALID_COST, 16'hFFFF);
            default: write_csr(scmcl_pkg::CSR_INVALID_COST, $urandom_range(65535));
         endcase
         write_csr(scmcl_pkg::CSR_ID_COUNT, n);
         if (phase == 2) write_csr(scmcl_pkg::CSR_IMAGE_BYTES, total - 1);
         else if (phase % 4 == 3) write_csr(scmcl_pkg::CSR_IMAGE_BYTES, 21'h1FFFFF);
         else write_csr(scmcl_pkg::CSR_IMAGE_BYTES, total + $urandom_range(64));
         load_image(img_q);
         add_op(scmcl_pkg::FUNC_BUILD, 0, 0, 0, 0);
         for (int k = 0; k < (phase < 3 ? 12 : $urandom_range(50, 110)); k++) begin
            pick = $urandom_range(99);
            r = ($urandom_range(3) != 0) ? 12'($urandom_range(n - 1)) : 12'($urandom);
            c = ($urandom_range(3) != 0) ? 12'($urandom_range(n - 1)) : 12'($urandom);
            if (pick < 4) add_op(scmcl_pkg::FUNC_CLEAR, 18'($urandom), $urandom, r, c);
            else if (pick < 7) add_op(scmcl_pkg::FUNC_BUILD, 18'($urandom), $urandom, r, c);
            // writes far above the image, or new default costs, keep the layout intact
            else if (pick < 12)
               add_op(scmcl_pkg::FUNC_WRITE, 18'h20000 | 18'($urandom), $urandom, r, c);
            else if (pick < 15) add_op(scmcl_pkg::FUNC_WRITE, 0, $urandom, r, c);
            else add_op(scmcl_pkg::FUNC_LOOKUP, 18'($urandom), $urandom, r, c);
         end
         wait_drained();
         phase++;
      end

      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
